[rtl/i2rd_pkg.sv]
// shared constants, types and the digit table lookup of the radix conversion unit
`timescale 1ns / 1ps
`default_nettype none

package i2rd_pkg;

    // defaults of the top level parameters
    localparam int NUM_WIDTH_DEF = 32;
    localparam int MAX_BASE_DEF  = 16;

    // smallest base that makes sense
    localparam int MIN_BASE = 2;

    // long division steps done per clock in the back end
    localparam int DIV_STEPS = 8;

    // the digit table holds 16 characters of 8 bits
    localparam int CHAR_W      = 8;
    localparam int DIGIT_IDX_W = 4;
    localparam int TABLE_W     = 64;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH  = 2'd2;

    // configuration reset values: base ten; digit table '1'..'8' in the low half, '8' then seven 'D' in the high half
    localparam logic [7:0]         DIGIT_COUNT_RST = 8'd10;
    localparam logic [TABLE_W-1:0] CHARS_LOW_RST   = 64'd4050765991979987505;
    localparam logic [TABLE_W-1:0] CHARS_HIGH_RST  = 64'd4919131752989213752;

    // back end sequencer
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_SIGN,
        BS_EMIT
    } t_back_state;

    // picks the character byte for one digit value
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [TABLE_W-1:0]     chars_low,
        input logic [TABLE_W-1:0]     chars_high,
        input logic [DIGIT_IDX_W-1:0] value
    );
        logic [TABLE_W-1:0] word;
        word = value[DIGIT_IDX_W-1] ? chars_high : chars_low;
        return word[value[DIGIT_IDX_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

[rtl/i2rd_front.sv]
// front end: takes numbers, drops them under a bad base, forms sign and magnitude
`timescale 1ns / 1ps
`default_nettype none

module i2rd_front
    import i2rd_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF,
    parameter int MAX_BASE  = MAX_BASE_DEF
) (
    input  wire logic                        i_start,
    input  wire logic signed [NUM_WIDTH-1:0] i_number,
    input  wire logic [7:0]                  i_digit_count,
    input  wire logic                        i_full,
    output logic                             o_busy,
    output logic                             o_push,
    output logic [NUM_WIDTH:0]               o_item
);

    logic                 base_ok;
    logic                 neg;
    logic [NUM_WIDTH-1:0] raw;
    logic [NUM_WIDTH-1:0] mag;

    assign base_ok = (i_digit_count >= 8'(MIN_BASE)) && (i_digit_count <= 8'(MAX_BASE));

    assign raw = i_number;
    assign neg = raw[NUM_WIDTH-1];
    // unsigned negation, so the most negative value keeps its magnitude
    assign mag = neg ? (NUM_WIDTH'(0) - raw) : raw;

    assign o_busy = i_full;
    assign o_push = i_start && !i_full && base_ok;
    assign o_item = {neg, mag};

endmodule

`default_nettype wire

[rtl/i2rd_queue.sv]
// two entry queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module i2rd_queue
    import i2rd_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [NUM_WIDTH:0] i_data,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output logic [NUM_WIDTH:0]      o_data
);

    logic [NUM_WIDTH:0] r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/i2rd_back.sv]
// back end: digit by digit long division, digit stack and character output
`timescale 1ns / 1ps
`default_nettype none

module i2rd_back
    import i2rd_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF,
    parameter int MAX_BASE  = MAX_BASE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  wire logic [NUM_WIDTH:0]   i_item,
    input  wire logic [$clog2(MAX_BASE):0] i_base,
    input  wire logic [TABLE_W-1:0]   i_chars_low,
    input  wire logic [TABLE_W-1:0]   i_chars_high,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [CHAR_W-1:0]         o_character,
    output logic                      o_last_char
);

    localparam int DW    = $clog2(MAX_BASE);
    localparam int AW    = $clog2(NUM_WIDTH);
    localparam int CYC   = (NUM_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W = CYC * DIV_STEPS;
    localparam int SW    = (CYC > 1) ? $clog2(CYC) : 1;

    t_back_state r_state;
    t_back_state n_state;

    logic [PAD_W-1:0] r_quo;
    logic [DW-1:0]    r_rem;
    logic [SW-1:0]    r_step;
    logic [AW-1:0]    r_nd;
    logic [AW-1:0]    r_rd;
    logic             r_neg;

    logic [DW-1:0]    r_stack [NUM_WIDTH];
    logic [DW-1:0]    r_rdata;
    logic             r_pend;
    logic             r_pend_last;
    logic             r_sign_pend;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic [PAD_W-1:0] div_quo;
    logic [DW-1:0]    div_rem;
    logic             digit_done;
    logic             conv_done;

    // several restoring steps per clock on a remainder narrower than the base
    always_comb begin
        logic [DW:0]      part;
        logic [PAD_W-1:0] quo;
        logic [DW-1:0]    rem;
        quo = r_quo;
        rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            part = {rem, quo[PAD_W-1]};
            if (part >= i_base) begin
                rem = DW'(part - i_base);
                quo = {quo[PAD_W-2:0], 1'b1};
            end else begin
                rem = part[DW-1:0];
                quo = {quo[PAD_W-2:0], 1'b0};
            end
        end
        div_quo = quo;
        div_rem = rem;
    end

    assign digit_done = (r_state == BS_DIV) && (r_step == SW'(CYC - 1));
    assign conv_done  = digit_done && ((div_quo == '0) || (r_nd == AW'(NUM_WIDTH - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                if (conv_done) begin
                    n_state = r_neg ? BS_SIGN : BS_EMIT;
                end
            end
            BS_SIGN: begin
                n_state = BS_EMIT;
            end
            BS_EMIT: begin
                if (r_rd == '0) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop = 1'b0;
        unique case (r_state)
            BS_IDLE: o_pop = !i_empty;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_pend      <= 1'b0;
            r_sign_pend <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= (r_state == BS_EMIT);
            r_sign_pend <= (r_state == BS_SIGN);
            r_valid     <= r_pend || r_sign_pend;
        end
    end

    // division datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                r_quo  <= PAD_W'(i_item[NUM_WIDTH-1:0]);
                r_neg  <= i_item[NUM_WIDTH];
                r_rem  <= '0;
                r_step <= '0;
                r_nd   <= '0;
            end
            BS_DIV: begin
                r_quo <= div_quo;
                if (digit_done) begin
                    r_rem  <= '0;
                    r_step <= '0;
                    r_nd   <= r_nd + AW'(1);
                    r_rd   <= r_nd;
                end else begin
                    r_rem  <= div_rem;
                    r_step <= r_step + SW'(1);
                end
            end
            BS_EMIT: begin
                r_rd <= r_rd - AW'(1);
            end
            default: begin
                r_rd <= r_rd;
            end
        endcase
    end

    // digit stack, filled least significant first and read back in reverse
    always_ff @(posedge i_clk) begin
        if (digit_done) begin
            r_stack[r_nd] <= div_rem;
        end
        r_rdata     <= r_stack[r_rd];
        r_pend_last <= (r_rd == '0);
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_char <= r_sign_pend ? MINUS_CHAR
                              : digit_char(i_chars_low, i_chars_high, DIGIT_IDX_W'(r_rdata));
        r_last <= r_pend && r_pend_last;
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

[rtl/integer_to_radix_digits_unit.sv]
// top level of the signed integer to radix character conversion unit
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed NUM_WIDTH-bit number per command into its text in the
// configured base, one character byte per result word, most significant
// digit first, with o_last_char set on the final byte of the run.
// command channel: a number is taken at a clock edge with i_start high and
//   o_busy low; o_busy rises only while the two entry queue is full
// result channel: each word is on o_character / o_last_char for one cycle
//   with o_valid high; the receiver cannot stall, so no back pressure exists
// config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects digit count, low or high half of the digit table; other indexes
//   are dropped; write only while no conversion is pending
// a negative number gives a leading minus sign; an out of range base gives
//   no words at all
// timing: the divider retires DIV_STEPS quotient bits per clock; the back end
//   takes the next number from the queue only once its sequencer is idle again
// reset: synchronous, clears the queue and sequencer and loads base ten with
//   the reset digit table of i2rd_pkg

module integer_to_radix_digits_unit
    import i2rd_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF,
    parameter int MAX_BASE  = MAX_BASE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic signed [NUM_WIDTH-1:0] i_number,
    // result channel
    output logic                             o_valid,
    output logic [CHAR_W-1:0]                o_character,
    output logic                             o_last_char,
    // configuration channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [TABLE_W-1:0]          i_cfg_data
);

    localparam int DW = $clog2(MAX_BASE);

    // configuration registers
    logic [7:0]         r_digit_count;
    logic [TABLE_W-1:0] r_chars_low;
    logic [TABLE_W-1:0] r_chars_high;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [NUM_WIDTH:0] q_in;
    logic [NUM_WIDTH:0] q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RST;
            r_chars_low   <= CHARS_LOW_RST;
            r_chars_high  <= CHARS_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data[7:0];
                CFG_CHARS_LOW:   r_chars_low   <= i_cfg_data;
                CFG_CHARS_HIGH:  r_chars_high  <= i_cfg_data;
                default: begin
                    // unknown index, write dropped
                    r_digit_count <= r_digit_count;
                end
            endcase
        end
    end

    // front end validates the base and forms sign plus magnitude
    i2rd_front #(
        .NUM_WIDTH (NUM_WIDTH),
        .MAX_BASE  (MAX_BASE)
    ) u_front (
        .i_start       (i_start),
        .i_number      (i_number),
        .i_digit_count (r_digit_count),
        .i_full        (q_full),
        .o_busy        (o_busy),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    // decouples command intake from conversion
    i2rd_queue #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // back end divides, stacks digits and emits characters
    i2rd_back #(
        .NUM_WIDTH (NUM_WIDTH),
        .MAX_BASE  (MAX_BASE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_item       (q_out),
        .i_base       (r_digit_count[DW:0]),
        .i_chars_low  (r_chars_low),
        .i_chars_high (r_chars_high),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .o_character  (o_character),
        .o_last_char  (o_last_char)
    );

endmodule

`default_nettype wire
